// ===== design/first_fit_heap_allocator_assert.svh =====
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FFHA_ASSERT(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("ffha check failed");
`define FFHA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ffha check failed");
`else
`define FFHA_ASSERT(name, cond)
`define FFHA_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== design/ffha_pkg.sv =====
// Shared types and codes of the first-fit heap allocator.
package ffha_pkg;
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE,
        S_SRD, S_SEV, S_URD, S_UWR, S_WHIT, S_WNEW,
        S_FRD, S_FEV, S_CRD0, S_CEV0, S_NRD, S_NEV, S_DRD, S_DWR,
        S_DONE
    } t_state;
endpackage

// ===== design/first_fit_heap_allocator.sv =====
// First-fit heap allocator: descriptor table in one RAM, walked by a sequencer.
// Every descriptor visit is a RAM read followed by an evaluate step.
// Alloc: find the first fitting free entry; a split shifts later entries up and writes both halves.
// Free: find and mark the entry free, then a merge pass joins free neighbours, moving entries down.
// Miss walks the whole table; null free skips it. One item in flight; the next enters as the result shows.
// Reset: the init state writes the initial free descriptor; no item is taken meanwhile.
`include "first_fit_heap_allocator_assert.svh"
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 1048576,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [20:0] i_request_size,
    input  logic [20:0] i_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [20:0] o_granted_address,
    output logic [1:0]  o_status
);
    import ffha_pkg::*;

    localparam int HW = $clog2(HEAP_BYTES + 1);
    localparam int SW = (HW > 21 ? HW : 21) + 1;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = 2 * SW + 1;
    localparam logic [SW-1:0] HDR       = SW'(HEADER_BYTES);
    localparam logic [SW-1:0] INIT_SIZE = SW'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_BLOCKS);

    t_state r_state, n_state;
    logic [SW-1:0] r_req, n_req, r_addr, n_addr;
    logic [CW-1:0] r_cnt, n_cnt, r_idx, n_idx, r_j, n_j;
    logic [EW-1:0] r_ent, n_ent, r_new, n_new;
    logic [20:0]   r_grant, n_grant, r_ogrant, n_ogrant;
    logic [1:0]    r_stat, n_stat, r_ostat, n_ostat;
    logic          r_ovalid, n_ovalid;

    logic          w_we;
    logic [IW-1:0] w_waddr, w_raddr;
    logic [EW-1:0] w_wdata, w_rdata;
    logic [SW-1:0] rd_start, rd_size;
    logic          rd_free;
    logic [CW-1:0] w_i1, w_j1;
    logic          w_accept, w_out_free, w_fit, w_split, w_match, w_both;

    ffha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign rd_start   = w_rdata[EW-1:SW+1];
    assign rd_size    = w_rdata[SW:1];
    assign rd_free    = w_rdata[0];
    assign w_i1       = r_idx + 1'b1;
    assign w_j1       = r_j + 1'b1;
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_fit      = rd_free && (rd_size >= r_req);
    assign w_split    = (rd_size > r_req + HDR) && (r_cnt < CNT_MAX);
    assign w_match    = (rd_start + HDR) == r_addr;
    assign w_both     = r_ent[0] && rd_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: n_state = S_IDLE;
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_FREE) begin
                        n_state = (i_address == 21'd0) ? S_DONE : S_FRD;
                    end else begin
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD:  n_state = (r_idx == r_cnt) ? S_DONE : S_SEV;
            S_SEV:  n_state = w_fit ? (w_split ? S_URD : S_DONE) : S_SRD;
            S_URD:  n_state = (r_j > r_idx) ? S_UWR : S_WHIT;
            S_UWR:  n_state = S_URD;
            S_WHIT: n_state = S_WNEW;
            S_WNEW: n_state = S_DONE;
            S_FRD:  n_state = (r_idx == r_cnt) ? S_DONE : S_FEV;
            S_FEV:  n_state = w_match ? S_CRD0 : S_FRD;
            S_CRD0: n_state = S_CEV0;
            S_CEV0: n_state = S_NRD;
            S_NRD:  n_state = (w_i1 < r_cnt) ? S_NEV : S_DONE;
            S_NEV:  n_state = w_both ? S_DRD : S_NRD;
            S_DRD:  n_state = (w_j1 < r_cnt) ? S_DWR : S_NRD;
            S_DWR:  n_state = S_DRD;
            S_DONE: n_state = w_out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_req    = r_req;
        n_addr   = r_addr;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_j      = r_j;
        n_ent    = r_ent;
        n_new    = r_new;
        n_grant  = r_grant;
        n_stat   = r_stat;
        n_ovalid = r_ovalid;
        n_ogrant = r_ogrant;
        n_ostat  = r_ostat;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wdata  = '0;
        w_raddr  = '0;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_wdata = {{SW{1'b0}}, INIT_SIZE, 1'b1};
                n_cnt   = CW'(1);
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_req   = SW'(i_request_size);
                    n_addr  = SW'(i_address);
                    n_idx   = '0;
                    n_grant = '0;
                    n_stat  = ST_OK;
                end
            end
            S_SRD: begin
                if (r_idx == r_cnt) begin
                    n_stat = ST_NOFIT;
                end else begin
                    w_raddr = r_idx[IW-1:0];
                end
            end
            S_SEV: begin
                if (w_fit) begin
                    n_grant = 21'(rd_start + HDR);
                    if (w_split) begin
                        n_ent = {rd_start, r_req, 1'b0};
                        n_new = {rd_start + HDR + r_req, rd_size - r_req - HDR, 1'b1};
                        n_j   = r_cnt - 1'b1;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = r_idx[IW-1:0];
                        w_wdata = {rd_start, rd_size, 1'b0};
                    end
                end else begin
                    n_idx = w_i1;
                end
            end
            S_URD: begin
                if (r_j > r_idx) begin
                    w_raddr = r_j[IW-1:0];
                end
            end
            S_UWR: begin
                w_we    = 1'b1;
                w_waddr = w_j1[IW-1:0];
                w_wdata = w_rdata;
                n_j     = r_j - 1'b1;
            end
            S_WHIT: begin
                w_we    = 1'b1;
                w_waddr = r_idx[IW-1:0];
                w_wdata = r_ent;
            end
            S_WNEW: begin
                w_we    = 1'b1;
                w_waddr = w_i1[IW-1:0];
                w_wdata = r_new;
                n_cnt   = r_cnt + 1'b1;
            end
            S_FRD: begin
                if (r_idx == r_cnt) begin
                    n_stat = ST_NOTFOUND;
                end else begin
                    w_raddr = r_idx[IW-1:0];
                end
            end
            S_FEV: begin
                if (w_match) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[IW-1:0];
                    w_wdata = {rd_start, rd_size, 1'b1};
                end else begin
                    n_idx = w_i1;
                end
            end
            S_CRD0: begin
                n_idx = '0;
            end
            S_CEV0: begin
                n_ent = w_rdata;
            end
            S_NRD: begin
                if (w_i1 < r_cnt) begin
                    w_raddr = w_i1[IW-1:0];
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[IW-1:0];
                    w_wdata = r_ent;
                end
            end
            S_NEV: begin
                if (w_both) begin
                    n_ent = {r_ent[EW-1:SW+1], r_ent[SW:1] + rd_size + HDR, 1'b1};
                    n_j   = w_i1;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[IW-1:0];
                    w_wdata = r_ent;
                    n_ent   = w_rdata;
                    n_idx   = w_i1;
                end
            end
            S_DRD: begin
                if (w_j1 < r_cnt) begin
                    w_raddr = w_j1[IW-1:0];
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DWR: begin
                w_we    = 1'b1;
                w_waddr = r_j[IW-1:0];
                w_wdata = w_rdata;
                n_j     = w_j1;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ogrant = r_grant;
                    n_ostat  = r_stat;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cnt    <= CW'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_req    <= n_req;
        r_addr   <= n_addr;
        r_idx    <= n_idx;
        r_j      <= n_j;
        r_ent    <= n_ent;
        r_new    <= n_new;
        r_grant  <= n_grant;
        r_stat   <= n_stat;
        r_ogrant <= n_ogrant;
        r_ostat  <= n_ostat;
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_ovalid;
    assign o_granted_address = r_ogrant;
    assign o_status          = r_ostat;

    `FFHA_ASSERT(a_cnt_range, (r_state == S_INIT) || (r_cnt >= CW'(1) && r_cnt <= CNT_MAX))
    `FFHA_ASSERT_NEXT(a_accept_busy, w_accept, r_state != S_IDLE)
    `FFHA_ASSERT(a_fail_no_grant, !o_valid || o_status == ST_OK || o_granted_address == 21'd0)
endmodule

// ===== design/ffha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the first-fit heap allocator: directed and random requests.
module testbench;
    import ffha_pkg::*;

    localparam int HEAP   = 1048576;
    localparam int HDR    = 24;
    localparam int SLOTS  = 64;
    localparam int LIMIT  = 4000000;

    typedef struct packed {
        logic [20:0] granted;
        logic [1:0]  status;
    } t_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_op = OP_ALLOC;
    logic [20:0] i_request_size = '0;
    logic [20:0] i_address = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [20:0] o_granted_address;
    logic [1:0]  o_status;

    first_fit_heap_allocator dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the descriptor table.
    int unsigned blk_start[SLOTS];
    int unsigned blk_size[SLOTS];
    bit          blk_free[SLOTS];
    int unsigned blk_count;

    t_grant expected_grants[$];
    int     send_idle_pct;
    int     recv_idle_pct;
    int     errors;
    int     cycles;

    task automatic remove_block(int unsigned idx);
        for (int unsigned j = idx; j + 1 < blk_count; j++) begin
            blk_start[j] = blk_start[j+1];
            blk_size[j]  = blk_size[j+1];
            blk_free[j]  = blk_free[j+1];
        end
        blk_count--;
    endtask

    task automatic predict_heap(logic op, logic [20:0] req, logic [20:0] addr);
        t_grant r;
        bit     hit;
        r = '{granted: '0, status: ST_OK};
        hit = 1'b0;
        if (op == OP_ALLOC) begin
            for (int unsigned i = 0; i < blk_count && !hit; i++) begin
                if (blk_free[i] && blk_size[i] >= req) begin
                    if (blk_size[i] > req + HDR && blk_count < SLOTS) begin
                        for (int unsigned j = blk_count; j > i + 1; j--) begin
                            blk_start[j] = blk_start[j-1];
                            blk_size[j]  = blk_size[j-1];
                            blk_free[j]  = blk_free[j-1];
                        end
                        blk_count++;
                        blk_start[i+1] = blk_start[i] + HDR + req;
                        blk_size[i+1]  = blk_size[i] - req - HDR;
                        blk_free[i+1]  = 1'b1;
                        blk_size[i]    = req;
                    end
                    blk_free[i] = 1'b0;
                    r.granted = 21'(blk_start[i] + HDR);
                    hit = 1'b1;
                end
            end
            if (!hit) r.status = ST_NOFIT;
        end else if (addr != 0) begin
            for (int unsigned i = 0; i < blk_count && !hit; i++) begin
                if (blk_start[i] + HDR == addr) begin
                    blk_free[i] = 1'b1;
                    hit = 1'b1;
                end
            end
            if (hit) begin
                int unsigned k;
                k = 0;
                while (k + 1 < blk_count) begin
                    if (blk_free[k] && blk_free[k+1]) begin
                        blk_size[k] = blk_size[k] + blk_size[k+1] + HDR;
                        remove_block(k + 1);
                    end else begin
                        k++;
                    end
                end
            end else begin
                r.status = ST_NOTFOUND;
            end
        end
        expected_grants.push_back(r);
    endtask

    task automatic send_item(logic op, logic [20:0] req, logic [20:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_request_size <= req;
        i_address      <= addr;
        do @(posedge i_clk); while (o_stall);
        predict_heap(op, req, addr);
    endtask

    task automatic wait_drained();
        while (expected_grants.size() != 0) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic logic [20:0] pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return 21'($urandom_range(0, 2000));
        if (r < 90) return 21'($urandom_range(0, 65536));
        if (r < 95) return 21'($urandom_range(0, HEAP));
        return 21'($urandom);
    endfunction

    // Data offset of a random allocated block, or 0 when none is allocated.
    function automatic logic [20:0] pick_used();
        int unsigned used[$];
        for (int unsigned i = 0; i < blk_count; i++)
            if (!blk_free[i]) used.push_back(i);
        if (used.size() == 0) return '0;
        return 21'(blk_start[used[$urandom_range(used.size() - 1)]] + HDR);
    endfunction

    task automatic test_directed();
        send_item(OP_ALLOC, 21'd0, 21'd0);
        send_item(OP_ALLOC, 21'd100, 21'h1FFFFF);
        send_item(OP_ALLOC, 21'd50, 21'd0);
        send_item(OP_ALLOC, 21'h1FFFFF, 21'd0);
        send_item(OP_ALLOC, 21'(HEAP), 21'd0);
        send_item(OP_FREE, 21'h1FFFFF, 21'd0);
        send_item(OP_FREE, 21'd0, 21'd1);
        send_item(OP_FREE, 21'd0, 21'h1FFFFF);
        send_item(OP_FREE, 21'd0, 21'd47);
        send_item(OP_FREE, 21'd0, 21'd48);
        send_item(OP_FREE, 21'd0, 21'd48);
        send_item(OP_ALLOC, 21'd90, 21'd0);
        send_item(OP_FREE, 21'd0, 21'd24);
        send_item(OP_FREE, 21'd0, 21'd172);
        send_item(OP_FREE, 21'd0, 21'd48);
        send_item(OP_ALLOC, 21'(HEAP - HDR), 21'd0);
        send_item(OP_ALLOC, 21'd0, 21'd0);
        send_item(OP_FREE, 21'd0, 21'd24);
        send_item(OP_ALLOC, 21'(HEAP - 2 * HDR), 21'd0);
        send_item(OP_FREE, 21'd0, 21'd24);
        for (int n = 0; n < 5; n++) send_item(OP_ALLOC, 21'd1, 21'd0);
    endtask

    task automatic test_random(int items, int alloc_pct);
        int unsigned r;
        logic [20:0] a;
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(99);
            if (r < alloc_pct) begin
                send_item(OP_ALLOC, pick_size(), 21'($urandom));
            end else if (r < 92) begin
                a = pick_used();
                send_item(OP_FREE, 21'($urandom), a);
            end else begin
                a = pick_used();
                case ($urandom_range(3))
                    0: a = 21'($urandom);
                    1: a = a + 21'd1;
                    2: a = '0;
                    default: a = 21'(blk_start[$urandom_range(blk_count - 1)] + HDR);
                endcase
                send_item(OP_FREE, 21'($urandom), a);
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_grants.size() == 0) begin
                $error("unexpected result: granted_address %0d status %0d",
                       o_granted_address, o_status);
                errors++;
            end else begin
                want = expected_grants.pop_front();
                if (o_granted_address !== want.granted) begin
                    $error("granted_address expected %0d actual %0d",
                           want.granted, o_granted_address);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        send_idle_pct = 26;
        recv_idle_pct = 52;
        blk_start = '{default: 0};
        blk_size  = '{default: 0};
        blk_free  = '{default: 0};
        blk_start[0] = 0;
        blk_size[0]  = HEAP - HDR;
        blk_free[0]  = 1'b1;
        blk_count    = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(600, 72);
        wait_drained();
        send_idle_pct = 52;
        recv_idle_pct = 26;
        test_random(600, 55);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(550, 62);
        wait_drained();
        repeat (1000) @(posedge i_clk);

        if (errors == 0 && expected_grants.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
